>>> hdl/lmvs_pkg.sv
package lmvs_pkg;

    // Defaults and fixed field widths
    localparam int MAX_ROW_WIDTH_DEF = 8192;
    localparam int ROW_W             = 14;
    localparam int PIXEL_W           = 8;
    localparam int VALUE_W           = 30;
    localparam int FRAC_BITS         = 8;
    localparam int CFG_INDEX_W       = 2;
    localparam int JOB_QUEUE_DEPTH   = 2;

    // Scene-mode window geometry
    localparam int ROW_WIDTH_RESET = 3150;
    localparam int SCENE_WINDOW    = 3150;
    localparam int OFFSET_BIAS     = 32;
    localparam int OFFSET_BYTE0    = 24;
    localparam int START_MIN       = 28;
    localparam int START_LIMIT     = 1024;

    localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

    // Result kinds carried on tuser
    localparam logic KIND_FIRST    = 1'b0;
    localparam logic KIND_VARIANCE = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SUM_MODE        = 2'd0,
        REG_VARIANCE_ENABLE = 2'd1,
        REG_SCENE_MODE      = 2'd2,
        REG_ROW_WIDTH       = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic             sum_mode;
        logic             variance_enable;
        logic             scene_mode;
        logic [ROW_W-1:0] row_width;
    } cfg_t;

endpackage

>>> hdl/lmvs_front.sv
module lmvs_front #(
    parameter int WIN_MAX = 8192,
    parameter int COL_W   = 14,
    parameter int SUM_W   = 21,
    parameter int SQ_W    = 29
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  lmvs_pkg::cfg_t                        cfg,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [lmvs_pkg::PIXEL_W-1:0]          s_tdata,
    input  logic                                  q_full,
    output logic                                  job_push,
    output logic [SUM_W+SQ_W+lmvs_pkg::ROW_W+1:0] job_data
);
    import lmvs_pkg::*;

    logic [COL_W-1:0]     col_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [SQ_W-1:0]      sq_reg;
    logic [31:0]          word_reg;
    logic [31:0]          word_next;
    logic [SUM_W-1:0]     sum_next;
    logic [SQ_W-1:0]      sq_next;
    logic [ROW_W-1:0]     width_eff;
    logic [ROW_W-1:0]     win_len;
    logic [31:0]          col_ext;
    logic [31:0]          start_cur;
    logic [31:0]          start_end;
    logic [1:0]           byte_sel;
    logic [2*PIXEL_W-1:0] pix_sq;
    logic                 in_window;
    logic                 row_last;
    logic                 emit;
    logic                 accept;

    // Effective row width: zero acts as one, clamp to the supported maximum
    always_comb begin
        if (cfg.row_width == '0) begin
            width_eff = ROW_W'(1);
        end else if (32'(cfg.row_width) > 32'(WIN_MAX)) begin
            width_eff = ROW_W'(WIN_MAX);
        end else begin
            width_eff = cfg.row_width;
        end
    end

    assign col_ext  = 32'(col_reg);
    assign row_last = (col_ext + 32'd1) >= 32'(width_eff);
    // Stall only the row-closing pixel when the job queue is full
    assign s_tready = !(q_full && row_last);
    assign accept   = s_tvalid && s_tready;
    assign pix_sq   = (2*PIXEL_W)'(s_tdata) * (2*PIXEL_W)'(s_tdata);
    assign byte_sel = 2'(col_ext - 32'(OFFSET_BYTE0));

    // Window test and start word capture
    always_comb begin
        word_next = word_reg;
        start_cur = word_reg + 32'(OFFSET_BIAS);
        in_window = 1'b0;
        if (cfg.scene_mode) begin
            if (col_ext >= 32'(OFFSET_BYTE0) && col_ext < 32'(START_MIN)) begin
                word_next[{byte_sel, 3'b000} +: 8] = s_tdata;
            end else if (col_ext >= 32'(START_MIN)) begin
                in_window = (col_ext >= start_cur) &&
                            ((col_ext - start_cur) < 32'(SCENE_WINDOW));
            end
        end else begin
            in_window = 1'b1;
        end
    end

    assign sum_next = in_window ? sum_reg + SUM_W'(s_tdata) : sum_reg;
    assign sq_next  = in_window ? sq_reg + SQ_W'(pix_sq) : sq_reg;

    // Row-end decision: header lines give no job
    assign start_end = word_next + 32'(OFFSET_BIAS);
    assign emit      = !cfg.scene_mode ||
                       (start_end >= 32'(START_MIN) && start_end < 32'(START_LIMIT) &&
                        (33'(start_end) + 33'(SCENE_WINDOW)) <= 33'(width_eff));
    assign win_len   = cfg.scene_mode ? ROW_W'(SCENE_WINDOW) : width_eff;

    assign job_push = accept && row_last && emit;
    assign job_data = {cfg.sum_mode, cfg.variance_enable, win_len, sq_next, sum_next};

    // Accumulators and column counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            sum_reg  <= '0;
            sq_reg   <= '0;
            word_reg <= '0;
        end else if (accept) begin
            word_reg <= word_next;
            if (row_last) begin
                col_reg <= '0;
                sum_reg <= '0;
                sq_reg  <= '0;
            end else begin
                col_reg <= col_reg + COL_W'(1);
                sum_reg <= sum_next;
                sq_reg  <= sq_next;
            end
        end
    end

endmodule

>>> hdl/lmvs_queue.sv
module lmvs_queue #(
    parameter int DATA_W = 64,
    parameter int DEPTH  = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              full,
    output logic              empty
);
    import lmvs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = entry_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

>>> hdl/lmvs_div.sv
module lmvs_div #(
    parameter int NUM_W = 51,
    parameter int DEN_W = 28
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    import lmvs_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   rem_shift;
    logic [DEN_W:0]   rem_diff;
    logic             fits;

    // One restoring step: shift in next dividend bit, trial subtract
    assign rem_shift = {rem_reg, quo_reg[NUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign fits      = rem_shift >= {1'b0, den_reg};

    assign done = done_reg;
    assign quot = quo_reg;

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            den_reg <= den;
            quo_reg <= num;
        end else if (busy_reg) begin
            rem_reg <= fits ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    // Step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            cnt_reg  <= CNT_W'(NUM_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

endmodule

>>> hdl/lmvs_back.sv
module lmvs_back #(
    parameter int SUM_W = 21,
    parameter int SQ_W  = 29
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  q_empty,
    input  logic [SUM_W+SQ_W+lmvs_pkg::ROW_W+1:0] q_data,
    output logic                                  q_pop,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [lmvs_pkg::VALUE_W-1:0]          m_value,
    output logic                                  m_kind,
    output logic                                  m_last
);
    import lmvs_pkg::*;

    localparam int A_W    = ROW_W + SQ_W;
    localparam int B_W    = 2 * SUM_W;
    localparam int PROD_W = (A_W > B_W) ? A_W : B_W;
    localparam int DIV_W  = PROD_W + FRAC_BITS;
    localparam int DEN_W  = 2 * ROW_W;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_MUL      = 4'b0010,
        ST_DIV_MEAN = 4'b0100,
        ST_DIV_VAR  = 4'b1000
    } back_state_t;

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [SUM_W-1:0]   sum_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic [ROW_W-1:0]   n_reg;
    logic               sum_mode_reg;
    logic               var_en_reg;
    logic [A_W-1:0]     a_reg;
    logic [B_W-1:0]     b_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [A_W-1:0]     a_prod;
    logic [B_W-1:0]     b_prod;
    logic [DEN_W-1:0]   den_prod;
    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_kind_reg;
    logic               out_last_reg;
    logic               out_free;
    logic               load_out;
    logic               var_ok;
    logic [PROD_W-1:0]  var_diff;
    logic               div_start;
    logic [DIV_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;
    logic               div_done;
    logic [DIV_W-1:0]   div_quot;
    logic [DIV_W-1:0]   result_wide;
    logic [VALUE_W-1:0] result_sat;

    // Products for the variance numerator and denominator
    assign a_prod   = A_W'(n_reg) * A_W'(sq_reg);
    assign b_prod   = B_W'(sum_reg) * B_W'(sum_reg);
    assign den_prod = DEN_W'(n_reg) * DEN_W'(n_reg - ROW_W'(1));

    assign var_ok   = (n_reg > ROW_W'(1)) && (PROD_W'(a_reg) > PROD_W'(b_reg));
    assign var_diff = PROD_W'(a_reg) - PROD_W'(b_reg);

    assign out_free = !out_valid_reg || m_tready;
    assign load_out = (state_reg == ST_DIV_MEAN || state_reg == ST_DIV_VAR) &&
                      div_done && out_free;

    // Pick and saturate the statistic
    always_comb begin
        if (state_reg == ST_DIV_VAR) begin
            result_wide = div_quot;
        end else if (sum_mode_reg) begin
            result_wide = DIV_W'(sum_reg) << FRAC_BITS;
        end else begin
            result_wide = div_quot;
        end
        result_sat = (result_wide > DIV_W'(VALUE_MAX)) ? VALUE_MAX
                                                        : result_wide[VALUE_W-1:0];
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        div_start  = 1'b0;
        div_num    = DIV_W'(sum_reg) << FRAC_BITS;
        div_den    = DEN_W'(n_reg);
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                div_start  = 1'b1;
                state_next = ST_DIV_MEAN;
            end
            ST_DIV_MEAN: begin
                if (load_out) begin
                    if (var_en_reg) begin
                        div_start  = 1'b1;
                        div_num    = var_ok ? DIV_W'(var_diff) << FRAC_BITS : '0;
                        div_den    = var_ok ? den_reg : DEN_W'(1);
                        state_next = ST_DIV_VAR;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DIV_VAR: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    lmvs_div #(
        .NUM_W (DIV_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Job latch and products
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            {sum_mode_reg, var_en_reg, n_reg, sq_reg, sum_reg} <= q_data;
        end
        if (state_reg == ST_MUL) begin
            a_reg   <= a_prod;
            b_reg   <= b_prod;
            den_reg <= den_prod;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_value_reg <= result_sat;
            out_kind_reg  <= (state_reg == ST_DIV_VAR) ? KIND_VARIANCE : KIND_FIRST;
            out_last_reg  <= (state_reg == ST_DIV_VAR) || !var_en_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_value  = out_value_reg;
    assign m_kind   = out_kind_reg;
    assign m_last   = out_last_reg;

endmodule

>>> hdl/line_mean_variance_stats_core.sv
// Throughput: one pixel per cycle; a full job queue stalls only a row's last pixel.
// Each reported row occupies the back end and its shared radix-2 divider (DIV_W = 51
// at the default maximum row width), overlapped with the next row. The mean/sum goes
// out after queue, ST_MUL and mean division; the variance after a second division.
// Reset: synchronous active-low aresetn clears counters, sums, queue and output,
// and loads register defaults; nothing needs a clearing pass.
module line_mean_variance_stats_core #(
    parameter int MAX_ROW_WIDTH = lmvs_pkg::MAX_ROW_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [lmvs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lmvs_pkg::ROW_W-1:0]         cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] pixel
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [31:0]                        m_tdata,   // [29:0] value, [31:30] zero
    output logic                               m_tuser,   // [0] kind
    output logic                               m_tlast
);
    import lmvs_pkg::*;

    localparam int ROW_MAX = (1 << ROW_W) - 1;
    localparam int WIN_MAX = (MAX_ROW_WIDTH < ROW_MAX) ? MAX_ROW_WIDTH : ROW_MAX;
    localparam int PIX_MAX = (1 << PIXEL_W) - 1;
    localparam int COL_W   = $clog2(WIN_MAX + 1);
    localparam int SUM_W   = $clog2(WIN_MAX * PIX_MAX + 1);
    localparam int SQ_W    = $clog2(WIN_MAX * PIX_MAX * PIX_MAX + 1);
    localparam int JOB_W   = SUM_W + SQ_W + ROW_W + 2;

    cfg_t               cfg_reg;
    logic               job_push;
    logic [JOB_W-1:0]   job_data;
    logic               q_pop;
    logic [JOB_W-1:0]   q_data;
    logic               q_full;
    logic               q_empty;
    logic [VALUE_W-1:0] m_value;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sum_mode        <= 1'b0;
            cfg_reg.variance_enable <= 1'b0;
            cfg_reg.scene_mode      <= 1'b0;
            cfg_reg.row_width       <= ROW_W'(ROW_WIDTH_RESET);
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SUM_MODE:        cfg_reg.sum_mode        <= cfg_data[0];
                REG_VARIANCE_ENABLE: cfg_reg.variance_enable <= cfg_data[0];
                REG_SCENE_MODE:      cfg_reg.scene_mode      <= cfg_data[0];
                REG_ROW_WIDTH:       cfg_reg.row_width       <= cfg_data;
                default: ;
            endcase
        end
    end

    lmvs_front #(
        .WIN_MAX (WIN_MAX),
        .COL_W   (COL_W),
        .SUM_W   (SUM_W),
        .SQ_W    (SQ_W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .job_push (job_push),
        .job_data (job_data)
    );

    lmvs_queue #(
        .DATA_W (JOB_W),
        .DEPTH  (JOB_QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .push_data (job_data),
        .pop       (q_pop),
        .pop_data  (q_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    lmvs_back #(
        .SUM_W (SUM_W),
        .SQ_W  (SQ_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_value  (m_value),
        .m_kind   (m_tuser),
        .m_last   (m_tlast)
    );

    assign m_tdata = {(32 - VALUE_W)'(0), m_value};

    // Checks on the front/back hand-over and result framing
    assert property (@(posedge aclk) disable iff (!aresetn) !(job_push && q_full))
        else $error("job pushed into a full queue");

    assert property (@(posedge aclk) disable iff (!aresetn) q_pop |-> !q_empty)
        else $error("job popped from an empty queue");

    assert property (@(posedge aclk) disable iff (!aresetn) !s_tready |-> q_full)
        else $error("input stalled while the job queue has room");

    assert property (@(posedge aclk) disable iff (!aresetn)
                     (m_tvalid && m_tuser == KIND_VARIANCE) |-> m_tlast)
        else $error("variance item not marked last");

endmodule
